// ===== rtl/q24_8_fixed_point_alu_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU
// ---------------------------------------------------------------------------
`ifndef Q24_8_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_TOP_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define ALU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alu check failed");

// Check a condition that holds at every edge
`define ALU_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("alu invariant failed");

`endif

// ===== rtl/qalu_pkg.sv =====
// ---------------------------------------------------------------------------
// qalu_pkg
// Shared opcodes, widths and the result flags record.
// ---------------------------------------------------------------------------
package qalu_pkg;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MIN = 4'd4;
  localparam logic [3:0] OP_MAX = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_DEC = 4'd7;
  localparam logic [3:0] OP_I2F = 4'd8;
  localparam logic [3:0] OP_F2I = 4'd9;

  // Result flags of one request
  typedef struct packed {
    logic a_greater;
    logic a_less;
    logic a_equal;
    logic overflow;
    logic divide_by_zero;
  } flags_t;
endpackage

// ===== rtl/qalu_front.sv =====
// ---------------------------------------------------------------------------
// qalu_front
// Accepts requests, truncates operands and classifies them into a queue.
// ---------------------------------------------------------------------------
module qalu_front import qalu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_op,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  output logic        q_valid,
  input  logic        q_ready,
  output logic [3:0]  q_op,
  output logic signed [DATA_WIDTH-1:0] q_a,
  output logic signed [DATA_WIDTH-1:0] q_b,
  output logic [2:0]  q_cmp
);
  localparam int DEPTH = 1 << DEPTH_LOG2;
  localparam int EW = 4 + 2 * DATA_WIDTH + 3;

  logic [EW-1:0] mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wptr, rptr;
  logic [DEPTH_LOG2:0] count;
  logic signed [DATA_WIDTH-1:0] a, b;
  logic [2:0] cmp;
  logic push, pop;

  // Classify: truncate operands and compare
  assign a = in_a[DATA_WIDTH-1:0];
  assign b = in_b[DATA_WIDTH-1:0];
  assign cmp = {a > b, a < b, a == b};

  assign in_ready = (count != DEPTH[DEPTH_LOG2:0]);
  assign q_valid = (count != '0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign {q_op, q_a, q_b, q_cmp} = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= {in_op, a, b, cmp};
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
    end
  end
endmodule

// ===== rtl/qalu_back.sv =====
// ---------------------------------------------------------------------------
// qalu_back
// Pipelined execution: decode/multiply/divider stages, then rounding and output.
// ---------------------------------------------------------------------------
module qalu_back import qalu_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  logic [3:0]  q_op,
  input  logic signed [DATA_WIDTH-1:0] q_a,
  input  logic signed [DATA_WIDTH-1:0] q_b,
  input  logic [2:0]  q_cmp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output flags_t      out_flags
);
  localparam int NW = DATA_WIDTH + FRAC_BITS;   // divide numerator width
  localparam int NS = NW + 2;                   // pipe stages
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [PW+1:0] VMAX = (PW+2)'((64'd1 << (DATA_WIDTH-1)) - 1);
  localparam logic signed [PW+1:0] VMIN = -VMAX - 1;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cmp;
    logic neg;
    logic dz;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic [NW-1:0] num;
    logic [DATA_WIDTH-1:0] den;
    logic [DATA_WIDTH:0] rem;
    logic signed [PW-1:0] prod;
  } stg_t;

  stg_t st [NS-1];
  logic [NS-2:0] vld;
  logic adv;
  logic out_full;
  logic [PW-1:0] pm, pq;
  logic signed [PW-1:0] prod_rnd;

  // Whole pipe advances unless the output register is held
  assign adv = !out_full || out_ready;
  assign q_ready = adv;
  assign out_valid = out_full;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic signed [DATA_WIDTH-1:0] v);
    mag = v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : v;
  endfunction

  // Stage 0: decode and multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].op   <= q_op;
      st[0].cmp  <= q_cmp;
      st[0].a    <= q_a;
      st[0].b    <= q_b;
      st[0].neg  <= q_a[DATA_WIDTH-1] ^ q_b[DATA_WIDTH-1];
      st[0].dz   <= (q_b == '0);
      st[0].num  <= {mag(q_a), {FRAC_BITS{1'b0}}};
      st[0].den  <= mag(q_b);
      st[0].rem  <= '0;
      st[0].prod <= PW'(q_a) * PW'(q_b);
    end
  end

  // Round the product to nearest, halves away from zero
  always_comb begin
    pm = st[0].prod[PW-1] ? PW'(-st[0].prod) : PW'(unsigned'(st[0].prod));
    pq = (pm + (PW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    prod_rnd = st[0].prod[PW-1] ? -$signed(pq) : $signed(pq);
  end

  // Divider: one restoring step per stage, quotient shifts into num
  for (genvar i = 1; i < NS - 1; i++) begin : g_div
    logic [DATA_WIDTH:0] tr;
    logic [DATA_WIDTH+1:0] diff;
    stg_t nxt;
    always_comb begin
      tr = {st[i-1].rem[DATA_WIDTH-1:0], st[i-1].num[NW-1]};
      diff = {1'b0, tr} - {2'b00, st[i-1].den};
      nxt = st[i-1];
      nxt.num = {st[i-1].num[NW-2:0], !diff[DATA_WIDTH+1]};
      nxt.rem = diff[DATA_WIDTH+1] ? tr : diff[DATA_WIDTH:0];
      nxt.prod = (i == 1) ? prod_rnd : st[i-1].prod;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[i] <= nxt;
      end
    end
  end

  // Final stage: round, saturate, select
  logic signed [PW+1:0] dres, ires;
  logic [NW:0] dq;
  logic [DATA_WIDTH+1:0] r2;
  logic [31:0] val;
  logic ovf, dzf;
  stg_t f;
  always_comb begin
    f = st[NS-2];
    ovf = 1'b0;
    dzf = 1'b0;
    ires = '0;
    r2 = {f.rem, 1'b0};
    dq = {1'b0, f.num} + (NW+1)'(r2 >= {2'b00, f.den});
    dres = f.neg ? -$signed((PW+2)'(dq)) : $signed((PW+2)'(dq));
    case (f.op)
      OP_ADD: ires = (PW+2)'(f.a) + (PW+2)'(f.b);
      OP_SUB: ires = (PW+2)'(f.a) - (PW+2)'(f.b);
      OP_MUL: ires = (PW+2)'(f.prod);
      OP_DIV: ires = f.dz ? (f.a[DATA_WIDTH-1] ? VMIN : VMAX) : dres;
      OP_MIN: ires = (f.a <= f.b) ? (PW+2)'(f.a) : (PW+2)'(f.b);
      OP_MAX: ires = (f.a <= f.b) ? (PW+2)'(f.b) : (PW+2)'(f.a);
      OP_INC: ires = (PW+2)'(f.a) + 1;
      OP_DEC: ires = (PW+2)'(f.a) - 1;
      OP_I2F: ires = (PW+2)'(f.a) <<< FRAC_BITS;
      OP_F2I: ires = (PW+2)'(f.a) >>> FRAC_BITS;
      default: ires = '0;
    endcase
    if (f.op == OP_DIV && f.dz) begin
      dzf = 1'b1;
    end else if (ires > VMAX) begin
      ires = VMAX;
      ovf = 1'b1;
    end else if (ires < VMIN) begin
      ires = VMIN;
      ovf = 1'b1;
    end
    val = 32'(ires);
  end

  // Valid bits along the pipe and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_full <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NS-3:0], q_valid};
      out_full <= vld[NS-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value <= val;
      out_flags <= '{a_greater: f.cmp[2], a_less: f.cmp[1], a_equal: f.cmp[0],
                     overflow: ovf, divide_by_zero: dzf};
    end
  end
endmodule

// ===== rtl/q24_8_fixed_point_alu_top.sv =====
// ---------------------------------------------------------------------------
// q24_8_fixed_point_alu_top
// Saturating signed fixed-point ALU with a decoupled classify front end.
// ---------------------------------------------------------------------------
// A request is taken every cycle unless the queue is full; the divider resolves
// one quotient bit per pipeline stage. A four-entry queue separates the
// front end from the execution pipe, and the whole pipe stalls with the output.
module q24_8_fixed_point_alu_top import qalu_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // req_type[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_value, a_greater, a_less, a_equal,
                                     // overflow, divide_by_zero, zero fill
);
  logic q_valid, q_ready;
  logic [3:0] q_op;
  logic signed [DATA_WIDTH-1:0] q_a, q_b;
  logic [2:0] q_cmp;
  logic [31:0] value;
  flags_t flags;

  qalu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_op(s_axis_tdata[3:0]), .in_a(s_axis_tdata[35:4]), .in_b(s_axis_tdata[67:36]),
    .q_valid, .q_ready, .q_op, .q_a, .q_b, .q_cmp
  );

  qalu_back #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_op, .q_a, .q_b, .q_cmp,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_value(value), .out_flags(flags)
  );

  assign m_axis_tdata = {3'b000, flags.divide_by_zero, flags.overflow, flags.a_equal,
                         flags.a_less, flags.a_greater, value};

`include "q24_8_fixed_point_alu_top_assert.svh"
  `ALU_ASSERT_ALWAYS(a_cmp_onehot, !m_axis_tvalid || $onehot(m_axis_tdata[34:32]))
  `ALU_ASSERT_ALWAYS(a_flags_excl, !m_axis_tvalid || !(m_axis_tdata[35] && m_axis_tdata[36]))
  `ALU_ASSERT_IMP(a_hold, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid)
endmodule

// ===== sim/q24_8_fixed_point_alu_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives opcode/operand requests through the input stream, predicts each
// result exactly (saturation, rounding, flags) and checks the output stream
// in order under several idle and stall patterns.
// ---------------------------------------------------------------------------
module q24_8_fixed_point_alu_top_tb;
  import qalu_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        ovf;
    logic        dz;
  } alu_res_t;

  // Predict one result from a request
  function automatic alu_res_t alu_predict(logic [3:0] op, logic [31:0] ra, logic [31:0] rb);
    alu_res_t    res;
    longint      a;
    longint      b;
    longint      r;
    longint      p;
    longint      vmax;
    longint      vmin;
    longint      num;
    longint      den;
    longint      q;
    longint      rem;
    logic        ovf;
    logic        dz;
    logic        neg;
    a    = longint'($signed(ra));
    b    = longint'($signed(rb));
    vmax = 64'sd2147483647;
    vmin = -vmax - 1;
    r    = 0;
    ovf  = 1'b0;
    dz   = 1'b0;
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: begin
        p = a * b;
        q = ((p < 0 ? -p : p) + 128) >>> 8;
        r = (p < 0) ? -q : q;
      end
      OP_DIV: begin
        if (b == 0) begin
          dz = 1'b1;
          r  = (a >= 0) ? vmax : vmin;
        end else begin
          num = (a < 0 ? -a : a) <<< 8;
          den = b < 0 ? -b : b;
          q   = num / den;
          rem = num % den;
          if (rem >= den - rem) q = q + 1;
          neg = (a < 0) != (b < 0);
          r   = neg ? -q : q;
        end
      end
      OP_MIN: r = (a <= b) ? a : b;
      OP_MAX: r = (a <= b) ? b : a;
      OP_INC: r = a + 1;
      OP_DEC: r = a - 1;
      OP_I2F: r = a * 256;
      OP_F2I: r = a >>> 8;
      default: r = 0;
    endcase
    // saturate
    if (r > vmax) begin
      r = vmax; ovf = 1'b1;
    end else if (r < vmin) begin
      r = vmin; ovf = 1'b1;
    end
    res.value = r[31:0];
    res.gt    = a > b;
    res.lt    = a < b;
    res.eq    = a == b;
    res.ovf   = ovf;
    res.dz    = dz;
    return res;
  endfunction

  class alu_scoreboard;
    alu_res_t pending_q[$];
    int       errors;
    int       checked;

    function void note_request(logic [71:0] req);
      pending_q.push_back(alu_predict(req[3:0], req[35:4], req[67:36]));
    endfunction

    task check_result(logic [39:0] word);
      alu_res_t want;
      alu_res_t got;
      got = {word[31:0], word[32], word[33], word[34], word[35], word[36]};
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", word));
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got !== want || word[39:37] !== 3'b000)
          report_mismatch($sformatf("got v=%h f=%b%b%b%b%b want v=%h f=%b%b%b%b%b",
            got.value, got.gt, got.lt, got.eq, got.ovf, got.dz,
            want.value, want.gt, want.lt, want.eq, want.ovf, want.dz));
      end
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", msg);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  alu_scoreboard sb = new();
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  longint cycles     = 0;
  int sent           = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  q24_8_fixed_point_alu_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Random receiver stall and output check
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
    if (cycles > 400000) begin
      $display("Timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one request, holding valid until accepted; drop valid while idle
  task send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, b, a, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request({4'b0, b, a, op});
    sent++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2047)) - 1024);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      3: return ($urandom() << 1) ^ 32'h8000_0000;
      4: return 32'($signed($urandom_range(65535)) - 32768) <<< 8;
      default: return {{8{$urandom_range(1) ? 1'b1 : 1'b0}}, 24'($urandom())};
    endcase
  endfunction

  task run_random(int count);
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    repeat (count) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      a  = rand_operand();
      b  = ($urandom_range(15) == 0) ? 32'd0 : rand_operand();
      if ($urandom_range(19) == 0) b = a;
      send_request(op, a, b);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners
    send_request(OP_ADD, 32'h7fffffff, 32'h00000001);
    send_request(OP_ADD, 32'h80000000, 32'h80000000);
    send_request(OP_SUB, 32'h80000000, 32'h00000001);
    send_request(OP_SUB, 32'h7fffffff, 32'hffffffff);
    send_request(OP_MUL, 32'h7fffffff, 32'h7fffffff);
    send_request(OP_MUL, 32'h80000000, 32'h80000000);
    send_request(OP_MUL, 32'h00000001, 32'h00000080);
    send_request(OP_MUL, 32'hffffffff, 32'h00000080);
    send_request(OP_DIV, 32'h00000100, 32'h00000000);
    send_request(OP_DIV, 32'hffffff00, 32'h00000000);
    send_request(OP_DIV, 32'h80000000, 32'h00000001);
    send_request(OP_DIV, 32'h80000000, 32'hffffffff);
    send_request(OP_DIV, 32'h00000001, 32'h00000200);
    send_request(OP_DIV, 32'hffffffff, 32'h00000200);
    send_request(OP_MIN, 32'h00000005, 32'h00000005);
    send_request(OP_MIN, 32'h80000000, 32'h7fffffff);
    send_request(OP_MAX, 32'h80000000, 32'h7fffffff);
    send_request(OP_INC, 32'h7fffffff, 32'h00000000);
    send_request(OP_DEC, 32'h80000000, 32'h00000000);
    send_request(OP_I2F, 32'h00800000, 32'h00000000);
    send_request(OP_I2F, 32'hff7fffff, 32'h00000000);
    send_request(OP_F2I, 32'hffffff01, 32'h00000000);
    send_request(OP_F2I, 32'h7fffffff, 32'h80000000);
    send_request(4'd15, 32'hffffffff, 32'hffffffff);
    // idle/stall phases
    run_random(475);
    send_idle_pct = 50;
    run_random(475);
    send_idle_pct = 0; stall_pct = 50;
    run_random(475);
    send_idle_pct = 13; stall_pct = 13;
    run_random(475);
    s_axis_tvalid <= 1'b0;
    stall_pct = 0; send_idle_pct = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d requests over all opcodes, %0d results checked,", sent, sb.checked);
    $display("with saturation, rounding, divide by zero and mixed stall phases.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
